// File: hw/rtl/mstc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mstc_pkg
// Types and fixed-point constants shared by the mount slew and track
// controller modules.
// ----------------------------------------------------------------------------
package mstc_pkg;

  localparam int FRAC_BITS = 20;
  localparam int RA_W      = 25;
  localparam int DEC_W     = 28;
  localparam int M_W       = 16;  // speed times step constant, up to 4 * STEP_K

  localparam int ONE_UNIT  = 1 << FRAC_BITS;
  localparam int FULL_RA   = 24 * ONE_UNIT;
  localparam int DEC_LIMIT = 90 * ONE_UNIT;
  localparam int STEP_K    = (ONE_UNIT + 50) / 100;
  localparam int TOL       = ONE_UNIT / 1000;
  localparam longint unsigned SIDEREAL_STEP =
      (64'd15041067 * (64'd1 << FRAC_BITS) + 64'd27000000000) / 64'd54000000000;

  localparam int SPEED_W     = 3;
  localparam int SPEED_MIN   = 1;
  localparam int SPEED_MAX   = 4;
  localparam int SPEED_RESET = 2;

  localparam logic signed [DEC_W-1:0] DEC_MAX = DEC_W'(DEC_LIMIT);
  localparam logic signed [DEC_W-1:0] DEC_MIN = -DEC_MAX;

  typedef enum logic [2:0] {
    FUNC_TICK   = 3'd0,
    FUNC_SLEW   = 3'd1,
    FUNC_SYNC   = 3'd2,
    FUNC_ABORT  = 3'd3,
    FUNC_TRACK  = 3'd4,
    FUNC_PARK   = 3'd5,
    FUNC_UNPARK = 3'd6
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_PARKED    = 2'd1,
    STAT_BAD_COORD = 2'd2
  } status_e;

  typedef struct packed {
    func_e                   func;
    logic [RA_W-1:0]         coord_ra;
    logic signed [DEC_W-1:0] coord_dec;
    logic                    track_enable;
  } in_item_t;

  typedef struct packed {
    status_e                 status;
    logic [RA_W-1:0]         out_ra;
    logic signed [DEC_W-1:0] out_dec;
    logic                    out_slewing;
    logic                    out_tracking;
    logic                    out_parked;
    logic                    out_aligned;
  } out_item_t;

  typedef struct packed {
    logic [RA_W-1:0]         pos_ra;
    logic signed [DEC_W-1:0] pos_dec;
    logic [RA_W-1:0]         goal_ra;
    logic signed [DEC_W-1:0] goal_dec;
    logic                    slewing;
    logic                    tracking;
    logic                    parked;
    logic                    aligned;
  } state_t;

  typedef struct packed {
    logic [RA_W-1:0]         pos_ra;
    logic signed [DEC_W-1:0] pos_dec;
    logic                    slewing;
  } tick_t;

endpackage
`default_nettype wire

// File: hw/rtl/mount_slew_track_controller_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mount_slew_track_controller_top
// Simulated equatorial mount: slew, sync, abort, tracking, park, unpark and tick
// commands on a fixed-point RA/Dec position, one result per request.
// ----------------------------------------------------------------------------
// Each request is registered at the input, executed against the mount state
// and its result is held in an output register; a new request is taken every
// cycle while the output side keeps up. The rate is set by the state loop: the
// tick step (two error-by-speed products, wrap and clamp) closes from the state
// registers back onto them with no register in between. The slew speed register
// takes 1 to 4; other writes are dropped. After reset the mount is parked at
// RA 0, Dec 0 with speed 2.
module mount_slew_track_controller_top
  import mstc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [SPEED_W-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_item_o
);

  logic           in_valid_q, in_valid_d;
  in_item_t       in_item_q;
  logic           out_valid_q, out_valid_d;
  out_item_t      out_item_q;
  out_item_t      result;
  logic [M_W-1:0] m_q;
  logic           exec, load_in;

  // request executes when the output register is free or being emptied
  assign exec       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !exec;
  assign load_in    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d  = load_in || (in_valid_q && !exec);
    out_valid_d = exec || (out_valid_q && out_stall_i);
  end

  mstc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .exec_i   (exec),
    .item_i   (in_item_q),
    .m_i      (m_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      m_q         <= M_W'(SPEED_RESET * STEP_K);
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && (cfg_wdata_i >= SPEED_W'(SPEED_MIN)) &&
          (cfg_wdata_i <= SPEED_W'(SPEED_MAX))) begin
        m_q <= M_W'(int'(cfg_wdata_i) * STEP_K);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_in) begin
      in_item_q <= in_item_i;
    end
    if (exec) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
`default_nettype wire

// File: hw/rtl/mstc_motion.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mstc_motion
// Position update for one tick: proportional slew step on both axes with
// RA wrap and Dec clamp, or the sidereal tracking increment.
// ----------------------------------------------------------------------------
module mstc_motion
  import mstc_pkg::*;
(
  input  state_t         state_i,
  input  logic [M_W-1:0] m_i,
  output tick_t          tick_o
);

  localparam int ERA_W  = RA_W + 1;
  localparam int EDEC_W = DEC_W + 1;
  localparam int PRA_W  = ERA_W + M_W + 1;
  localparam int PDEC_W = EDEC_W + M_W + 1;
  localparam int NRA_W  = RA_W + 2;
  localparam int NDEC_W = DEC_W + 2;

  localparam logic signed [ERA_W-1:0]  TOL_RA  = ERA_W'(TOL);
  localparam logic signed [EDEC_W-1:0] TOL_DEC = EDEC_W'(TOL);
  localparam logic signed [NRA_W-1:0]  FULL_N  = NRA_W'(FULL_RA);
  localparam logic signed [NDEC_W-1:0] DMAX_N  = NDEC_W'(DEC_LIMIT);
  localparam logic signed [NDEC_W-1:0] DMIN_N  = -DMAX_N;
  localparam logic [RA_W:0]            SID_INC = (RA_W+1)'(SIDEREAL_STEP);
  localparam logic [RA_W:0]            FULL_U  = (RA_W+1)'(FULL_RA);

  logic signed [ERA_W-1:0]  err_ra;
  logic signed [EDEC_W-1:0] err_dec;
  logic signed [PRA_W-1:0]  prod_ra;
  logic signed [PDEC_W-1:0] prod_dec;
  logic signed [NRA_W-1:0]  nra, nra_lo;
  logic signed [NDEC_W-1:0] ndec;
  logic [RA_W:0]            trk_sum;
  logic [RA_W-1:0]          trk_ra;
  logic                     slew_act, far, slew_after;

  always_comb begin
    err_ra  = $signed({1'b0, state_i.goal_ra}) - $signed({1'b0, state_i.pos_ra});
    err_dec = EDEC_W'(state_i.goal_dec) - EDEC_W'(state_i.pos_dec);
    far = (err_ra > TOL_RA) || (err_ra < -TOL_RA) ||
          (err_dec > TOL_DEC) || (err_dec < -TOL_DEC);

    // floor(err * m / 2^FRAC_BITS) is the upper part of the signed product
    prod_ra  = err_ra * $signed({1'b0, m_i});
    prod_dec = err_dec * $signed({1'b0, m_i});

    nra = $signed({2'b00, state_i.pos_ra}) + NRA_W'($signed(prod_ra[PRA_W-1:FRAC_BITS]));
    nra_lo = (nra < 0) ? nra + FULL_N : nra;
    if (nra_lo >= FULL_N) begin
      nra_lo = nra_lo - FULL_N;
    end

    ndec = NDEC_W'(state_i.pos_dec) + NDEC_W'($signed(prod_dec[PDEC_W-1:FRAC_BITS]));
    if (ndec > DMAX_N) begin
      ndec = DMAX_N;
    end
    if (ndec < DMIN_N) begin
      ndec = DMIN_N;
    end

    trk_sum = {1'b0, state_i.pos_ra} + SID_INC;
    trk_ra  = (trk_sum >= FULL_U) ? RA_W'(trk_sum - FULL_U) : RA_W'(trk_sum);

    slew_act   = state_i.slewing && !state_i.parked;
    slew_after = slew_act ? far : state_i.slewing;

    tick_o.pos_ra  = state_i.pos_ra;
    tick_o.pos_dec = state_i.pos_dec;
    tick_o.slewing = slew_after;
    if (slew_act && far) begin
      tick_o.pos_ra  = RA_W'(nra_lo);
      tick_o.pos_dec = DEC_W'(ndec);
    end else if (state_i.tracking && !state_i.parked && !slew_after) begin
      tick_o.pos_ra = trk_ra;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/mstc_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mstc_core
// Mount state registers and command decode. Builds the result for the
// request in the input register and commits the new state when it executes.
// ----------------------------------------------------------------------------
module mstc_core
  import mstc_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           exec_i,
  input  in_item_t       item_i,
  input  logic [M_W-1:0] m_i,
  output out_item_t      result_o
);

  // mount starts parked at the origin
  localparam state_t STATE_RESET = '{
    pos_ra:   '0,
    pos_dec:  '0,
    goal_ra:  '0,
    goal_dec: '0,
    slewing:  1'b0,
    tracking: 1'b0,
    parked:   1'b1,
    aligned:  1'b0
  };

  state_t  state_q, state_d;
  tick_t   tick;
  status_e status;
  logic    coord_ok;

  mstc_motion u_motion (
    .state_i (state_q),
    .m_i     (m_i),
    .tick_o  (tick)
  );

  always_comb begin
    state_d  = state_q;
    status   = STAT_OK;
    coord_ok = (item_i.coord_ra < RA_W'(FULL_RA)) &&
               (item_i.coord_dec >= DEC_MIN) && (item_i.coord_dec <= DEC_MAX);
    unique case (item_i.func)
      FUNC_TICK: begin
        state_d.pos_ra  = tick.pos_ra;
        state_d.pos_dec = tick.pos_dec;
        state_d.slewing = tick.slewing;
      end
      FUNC_SLEW, FUNC_SYNC: begin
        // parked check wins over the range check
        priority if (state_q.parked) begin
          status = STAT_PARKED;
        end else if (!coord_ok) begin
          status = STAT_BAD_COORD;
        end else if (item_i.func == FUNC_SLEW) begin
          state_d.goal_ra  = item_i.coord_ra;
          state_d.goal_dec = item_i.coord_dec;
          state_d.slewing  = 1'b1;
        end else begin
          state_d.pos_ra  = item_i.coord_ra;
          state_d.pos_dec = item_i.coord_dec;
          state_d.aligned = 1'b1;
        end
      end
      FUNC_ABORT: begin
        state_d.slewing = 1'b0;
      end
      FUNC_TRACK: begin
        if (state_q.parked) begin
          status = STAT_PARKED;
        end else begin
          state_d.tracking = item_i.track_enable;
        end
      end
      FUNC_PARK: begin
        if (!state_q.parked) begin
          state_d.slewing  = 1'b0;
          state_d.tracking = 1'b0;
          state_d.parked   = 1'b1;
        end
      end
      FUNC_UNPARK: begin
        state_d.parked = 1'b0;
      end
      default: begin
      end
    endcase

    result_o.status       = status;
    result_o.out_ra       = state_d.pos_ra;
    result_o.out_dec      = state_d.pos_dec;
    result_o.out_slewing  = state_d.slewing;
    result_o.out_tracking = state_d.tracking;
    result_o.out_parked   = state_d.parked;
    result_o.out_aligned  = state_d.aligned;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RESET;
    end else if (exec_i) begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire
